/* src/assert_macros.svh */
// ============================================================================
// assert_macros.svh
// Shared concurrent assertion macros for the reassembler RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_AT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(name, clk, rstn, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

/* src/cmfr_pkg.sv */
// ============================================================================
// cmfr_pkg
// Types and constants shared by the CAN multi-frame reassembler modules.
// ============================================================================
package cmfr_pkg;

    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 96;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [7:0] PAYLOAD_BYTES = 8'd5;

    localparam logic [1:0] ST_ACCEPTED     = 2'd0;
    localparam logic [1:0] ST_HDR_MISMATCH = 2'd1;
    localparam logic [1:0] ST_SEQ_MISMATCH = 2'd2;
    localparam logic [1:0] ST_OVERFLOW     = 2'd3;

    typedef struct packed {
        logic [7:0] sys_index;
        logic [3:0] sub_system;
        logic [7:0] sub_system_idx;
        logic [4:0] function_code;
        logic [6:0] data_obj;
        logic [5:0] data_elem;
    } hdr_t;

    typedef struct packed {
        hdr_t        hdr;
        logic        start_flag;
        logic [6:0]  frame_index;
        logic [39:0] payload;
    } frame_t;

endpackage

/* src/can_multi_frame_reassembler.sv */
// ============================================================================
// can_multi_frame_reassembler
// Reassembly checker for multi-frame CAN messages.
//
// s_axis carries one received frame per item: extended id and eight data
// bytes. m_axis returns one result per item: status in tuser, the message
// complete flag in tlast, and the decoded fields with the payload offset in
// tdata. Items are decoded on entry, held in a four-entry queue, then checked
// against the held header and countdown index by the engine.
// An accepted item passes through a queue entry and then the result register.
// Throughput: one item per cycle while m_axis_tready is high.
// Reset: queue empty, held header, index, byte count and complete flag zero;
// a continuation before any start item is rejected as a header or sequence mismatch.
// Stall: while m_axis_tready is low the result register holds its item, the
// queue fills, and s_axis_tready drops once all four queue entries are used.
// ============================================================================
module can_multi_frame_reassembler
    import cmfr_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // ext_id[28:0], frame_data[92:29], zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // start_flag[0], frame_index[7:1], byte_offset[15:8], payload[55:16],
    // sys_index[63:56], sub_system[67:64], sub_system_idx[75:68],
    // function_code[80:76], data_obj[87:81], data_elem[93:88], zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]             m_axis_tuser,
    output logic                   m_axis_tlast
);

    frame_t     dec_frame;
    frame_t     head_frame;
    frame_t     out_frame;
    logic       head_valid;
    logic       pop;
    logic [7:0] out_offset;

    cmfr_decode u_decode
    (
        .tdata (s_axis_tdata),
        .frame (dec_frame)
    );

    cmfr_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s_axis_tvalid),
        .push_frame (dec_frame),
        .not_full   (s_axis_tready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_frame (head_frame)
    );

    cmfr_engine #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_engine
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_frame   (head_frame),
        .pop          (pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_status   (m_axis_tuser),
        .out_complete (m_axis_tlast),
        .out_frame    (out_frame),
        .out_offset   (out_offset)
    );

    assign m_axis_tdata = {2'b00,
                           out_frame.hdr.data_elem,
                           out_frame.hdr.data_obj,
                           out_frame.hdr.function_code,
                           out_frame.hdr.sub_system_idx,
                           out_frame.hdr.sub_system,
                           out_frame.hdr.sys_index,
                           out_frame.payload,
                           out_offset,
                           out_frame.frame_index,
                           out_frame.start_flag};

endmodule

/* src/cmfr_decode.sv */
// ============================================================================
// cmfr_decode
// Splits a received frame (identifier and data bytes) into header fields, start flag, index and payload.
// ============================================================================
module cmfr_decode
    import cmfr_pkg::*;
(
    input  logic [IN_TDATA_W-1:0] tdata,
    output frame_t                frame
);

    logic [28:0] id;
    logic [63:0] d;

    assign id = tdata[28:0];
    assign d  = tdata[92:29];

    always_comb
    begin
        frame.hdr.sys_index      = id[23:16];
        frame.hdr.sub_system     = id[13:10];
        frame.hdr.sub_system_idx = id[9:2];
        frame.hdr.function_code  = {id[1:0], d[2:0]};
        frame.hdr.data_obj       = {d[9:8], d[7:3]};
        frame.hdr.data_elem      = d[15:10];
        frame.start_flag         = d[23];
        frame.frame_index        = d[22:16];
        frame.payload            = d[63:24];
    end

endmodule

/* src/cmfr_queue.sv */
// ============================================================================
// cmfr_queue
// Short FIFO of decoded frames between the decode side and the engine.
// ============================================================================
`include "assert_macros.svh"

module cmfr_queue
    import cmfr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  frame_t push_frame,
    output logic   not_full,
    input  logic   pop,
    output logic   head_valid,
    output frame_t head_frame
);

    frame_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign not_full   = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_frame = entry_reg[rd_ptr_reg];
    assign do_push    = push && not_full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_frame;
        end
    end

    `ASSERT_NEVER(a_count_bound, clk, rst_n, count_reg > QCNT_W'(QUEUE_DEPTH), "queue count overrun")
    `ASSERT_AT(a_ptr_gap, clk, rst_n, (QPTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[QPTR_W-1:0]), "queue pointers disagree with count")

endmodule

/* src/cmfr_engine.sv */
// ============================================================================
// cmfr_engine
// Sequence checker and byte-offset tracker; drives the result register.
// ============================================================================
`include "assert_macros.svh"

module cmfr_engine
    import cmfr_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  frame_t     head_frame,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] out_status,
    output logic       out_complete,
    output frame_t     out_frame,
    output logic [7:0] out_offset
);

    localparam logic [8:0] BUF_LIMIT = 9'(BUFFER_BYTES);

    hdr_t       held_hdr_reg;
    logic [6:0] last_index_reg;
    logic [7:0] byte_count_reg;
    logic       done_reg;
    logic       done_next;

    logic       out_valid_reg;
    logic [1:0] out_status_reg;
    logic       out_complete_reg;
    frame_t     out_frame_reg;
    logic [7:0] out_offset_reg;

    logic [1:0] status_c;
    logic [7:0] base_c;
    logic       accept_c;

    assign pop = head_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        status_c = ST_ACCEPTED;
        if (!head_frame.start_flag)
        begin
            if (head_frame.hdr != held_hdr_reg)
            begin
                status_c = ST_HDR_MISMATCH;
            end
            else if (({1'b0, head_frame.frame_index} + 8'd1) != {1'b0, last_index_reg})
            begin
                status_c = ST_SEQ_MISMATCH;
            end
            else if (({1'b0, byte_count_reg} + {1'b0, PAYLOAD_BYTES}) > BUF_LIMIT)
            begin
                status_c = ST_OVERFLOW;
            end
        end
        accept_c  = (status_c == ST_ACCEPTED);
        base_c    = head_frame.start_flag ? 8'd0 : byte_count_reg;
        done_next = head_frame.start_flag ? 1'b0 : done_reg;
        if (accept_c && head_frame.frame_index == 7'd1)
        begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_hdr_reg   <= '0;
            last_index_reg <= '0;
            byte_count_reg <= '0;
            done_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (head_frame.start_flag)
                begin
                    held_hdr_reg <= head_frame.hdr;
                end
                if (accept_c)
                begin
                    byte_count_reg <= base_c + PAYLOAD_BYTES;
                    last_index_reg <= head_frame.frame_index;
                end
                done_reg <= done_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_status_reg   <= status_c;
            out_complete_reg <= done_next;
            out_frame_reg    <= head_frame;
            out_offset_reg   <= accept_c ? base_c : 8'd0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_complete = out_complete_reg;
    assign out_frame    = out_frame_reg;
    assign out_offset   = out_offset_reg;

    `ASSERT_AT(a_start_count, clk, rst_n, (pop && head_frame.start_flag) |=> (byte_count_reg == PAYLOAD_BYTES), "start item did not reset byte count")
    `ASSERT_AT(a_reject_hold, clk, rst_n, (pop && !accept_c) |=> ($stable(byte_count_reg) && $stable(last_index_reg)), "rejected item changed sequence state")

endmodule
